@@ hdl/pscm_pkg.sv @@
// Shared types and constants for the page size class mix block.
// Used by the front stage, job queue, back sequencer and the top level.
package pscm_pkg;

    localparam int          MAX_PAGES_IN_RUN_DEF = 65535;
    localparam int          MAX_RESULTS          = 48;
    localparam logic [3:0]  LARGEST_RESET        = 4'd8;
    localparam logic [3:0]  LARGEST_FLOOR        = 4'd8;
    localparam logic [20:0] TOTAL_SAT            = 21'h1FFFFF;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One classified request as handed from the front to the back.
    typedef struct packed {
        logic [20:0] req;
        logic [15:0] minc;
        logic [3:0]  top;
        logic        err;
    } t_job;

    // One result item.
    typedef struct packed {
        logic [3:0]  idx;
        logic [15:0] cnt;
        logic [20:0] total;
        logic        last;
        logic        err;
    } t_result;

endpackage

@@ hdl/pscm_front.sv @@
// Front stage: accepts requests, clamps the largest class and flags requests
// whose minimum class exceeds it. Depends on pscm_pkg.
module pscm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [20:0]        i_req,
    input  logic [15:0]        i_minc,
    input  logic [3:0]         i_largest,
    output logic               o_push,
    input  logic               i_push_ready,
    output pscm_pkg::t_job     o_job
);

    logic           r_valid;
    pscm_pkg::t_job r_job;
    logic [3:0]     top;
    logic [16:0]    top_size;

    assign top      = (i_largest < pscm_pkg::LARGEST_FLOOR) ? pscm_pkg::LARGEST_FLOOR
                                                             : i_largest;
    assign top_size = 17'd1 << top;

    assign o_ready = !r_valid || i_push_ready;
    assign o_push  = r_valid;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_job.req  <= i_req;
            r_job.minc <= i_minc;
            r_job.top  <= top;
            r_job.err  <= {1'b0, i_minc} > top_size;
        end
    end

endmodule

@@ hdl/pscm_queue.sv @@
// Short job queue between the front stage and the back sequencer.
// Depends on pscm_pkg for the job type and depth.
module pscm_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_push_ready,
    input  pscm_pkg::t_job     i_job,
    output logic               o_valid,
    input  logic               i_pop,
    output pscm_pkg::t_job     o_job
);

    pscm_pkg::t_job                     r_mem [pscm_pkg::QUEUE_DEPTH];
    logic [pscm_pkg::QUEUE_PTR_W-1:0]   r_wr_ptr;
    logic [pscm_pkg::QUEUE_PTR_W-1:0]   r_rd_ptr;
    logic [pscm_pkg::QUEUE_CNT_W-1:0]   r_count;
    logic                               do_push;
    logic                               do_pop;

    localparam logic [pscm_pkg::QUEUE_CNT_W-1:0] FULL =
        pscm_pkg::QUEUE_CNT_W'(pscm_pkg::QUEUE_DEPTH);
    localparam logic [pscm_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        pscm_pkg::QUEUE_PTR_W'(pscm_pkg::QUEUE_DEPTH - 1);

    assign o_push_ready = (r_count != FULL);
    assign o_valid      = (r_count != '0);
    assign o_job        = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ hdl/pscm_back.sv @@
// Back sequencer: walks the size classes of one job, one class per cycle while
// the output is free, and drives the result register. Depends on pscm_pkg.
module pscm_back #(
    parameter int MAX_PAGES_IN_RUN = pscm_pkg::MAX_PAGES_IN_RUN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_job_pop,
    input  pscm_pkg::t_job      i_job,
    output logic                o_valid,
    input  logic                i_ready,
    output pscm_pkg::t_result   o_result
);

    typedef enum logic {ST_IDLE, ST_WALK} t_state;

    localparam logic [15:0] MAX_RUN  = 16'(MAX_PAGES_IN_RUN);
    localparam logic [5:0]  LAST_N   = 6'(pscm_pkg::MAX_RESULTS - 1);
    localparam logic [21:0] SAT_WIDE = {1'b0, pscm_pkg::TOTAL_SAT};
    localparam logic [21:0] SAT_MARK = SAT_WIDE + 22'd1;

    t_state             r_state,     n_state;
    logic [3:0]         r_idx,       n_idx;
    logic [20:0]        r_need,      n_need;
    logic [15:0]        r_minc,      n_minc;
    logic [21:0]        r_total,     n_total;
    logic [5:0]         r_n,         n_n;
    logic               r_out_valid, n_out_valid;
    pscm_pkg::t_result  r_out,       n_out;

    logic               slot_free;
    logic [15:0]        size;
    logic               smallest;
    logic [15:0]        maxn;
    logic [21:0]        reach;
    logic               skip;
    logic [20:0]        quot;
    logic [20:0]        cnt0;
    logic [15:0]        capped;
    logic [21:0]        prod;
    logic signed [22:0] rem0;
    logic               bump;
    logic [15:0]        cnt;
    logic [21:0]        prodf;
    logic signed [22:0] rem;
    logic [21:0]        sum;
    logic [21:0]        tot;
    logic               fin;

    assign slot_free = !r_out_valid || i_ready;

    always_comb begin
        size     = 16'd1 << r_idx;
        smallest = (r_idx == 4'd0) || ((size >> 1) < r_minc);
        maxn     = MAX_RUN >> r_idx;
        reach    = {1'b0, r_need} + {4'b0, r_need[20:3]};
        skip     = !smallest && ({6'b0, size} > reach);
        quot     = r_need >> r_idx;
        cnt0     = (quot > 21'd1) ? quot : 21'd1;
        capped   = (cnt0 > {5'b0, maxn}) ? maxn : cnt0[15:0];
        prod     = {6'b0, capped} << r_idx;
        rem0     = $signed({2'b0, r_need}) - $signed({1'b0, prod});
        bump     = smallest && (rem0 > 23'sd0) && (capped < maxn);
        cnt      = capped + {15'b0, bump};
        prodf    = prod + (bump ? {6'b0, size} : 22'd0);
        rem      = rem0 - (bump ? $signed({7'b0, size}) : 23'sd0);
        sum      = r_total + prodf;
        tot      = (sum > SAT_WIDE) ? SAT_MARK : sum;
        fin      = (rem <= 23'sd0) || (r_n == LAST_N);
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_need      = r_need;
        n_minc      = r_minc;
        n_total     = r_total;
        n_n         = r_n;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_job_pop   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid && slot_free) begin
                    o_job_pop = 1'b1;
                    if (i_job.err) begin
                        // Minimum class above the largest: single error result.
                        n_out_valid = 1'b1;
                        n_out       = '{idx: 4'd0, cnt: 16'd0, total: 21'd0,
                                        last: 1'b1, err: 1'b1};
                    end else begin
                        n_state = ST_WALK;
                        n_idx   = i_job.top;
                        n_need  = i_job.req;
                        n_minc  = i_job.minc;
                        n_total = '0;
                        n_n     = '0;
                    end
                end
            end
            ST_WALK: begin
                if (slot_free) begin
                    if (skip) begin
                        n_idx = r_idx - 4'd1;
                    end else if (maxn == 16'd0) begin
                        if (smallest) begin
                            n_state     = ST_IDLE;
                            n_out_valid = 1'b1;
                            n_out       = '{idx: 4'd0, cnt: 16'd0, total: 21'd0,
                                            last: 1'b1, err: 1'b1};
                        end else begin
                            n_idx = r_idx - 4'd1;
                        end
                    end else begin
                        n_out_valid = 1'b1;
                        n_out.idx   = r_idx;
                        n_out.cnt   = cnt;
                        n_out.total = tot[21] ? pscm_pkg::TOTAL_SAT : tot[20:0];
                        n_out.last  = fin;
                        n_out.err   = 1'b0;
                        n_total     = tot;
                        n_n         = r_n + 6'd1;
                        n_need      = rem[20:0];
                        if (fin) begin
                            n_state = ST_IDLE;
                        end else if (cnt != maxn) begin
                            n_idx = r_idx - 4'd1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_n         <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_n         <= n_n;
        end
        r_idx   <= n_idx;
        r_need  <= n_need;
        r_minc  <= n_minc;
        r_total <= n_total;
        r_out   <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.err) |-> (r_out.last && r_out.cnt == 16'd0 &&
                                        r_out.total == 21'd0))
        else $error("error result not a lone zero result");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.err) |-> (r_out.cnt != 16'd0))
        else $error("non-error result with zero runs");

    a_result_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_n <= LAST_N))
        else $error("result count past the limit");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (r_state == ST_IDLE && slot_free))
        else $error("job taken while sequencer busy");
`endif

endmodule

@@ hdl/page_size_class_mix.sv @@
// Top level of the page size class mix block.
// Instantiates pscm_front, pscm_queue and pscm_back; depends on pscm_pkg.

// A request for a number of pages is split over power-of-two size classes,
// from the configured largest class down to the smallest class the minimum
// allows, and one result is given each time a class is used (a capped class
// may be used again), the final one carrying tlast. The front stage takes one
// request per cycle into a two-entry job queue while the queue has room. The
// back sequencer takes a job from the queue, then visits the classes from
// the largest down to the class where the walk ends, revisiting a class
// whose run count hit the cap (at most 48 results). A request with its
// minimum class above the largest class gives a single error result. The
// walk is paced by the one shared class step (shift, cap, subtract) in the
// back sequencer, and it pauses while a finished result waits in the output
// register.
module page_size_class_mix #(
    parameter int MAX_PAGES_IN_RUN = pscm_pkg::MAX_PAGES_IN_RUN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: largest_class_log2
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // request_pages[20:0], min_class_pages[36:21]
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // class_index[3:0], class_count[19:4],
                                        // total_pages[40:20]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // error[0]
);

    logic               cfg_write;
    logic [3:0]         r_largest_log2;
    logic               front_push;
    logic               queue_ready;
    pscm_pkg::t_job     front_job;
    logic               queue_valid;
    logic               queue_pop;
    pscm_pkg::t_job     queue_job;
    pscm_pkg::t_result  result;

    // Config register; the front samples it as each request is accepted,
    // so write it only while the block is idle.
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_largest_log2 <= pscm_pkg::LARGEST_RESET;
        end else if (cfg_write) begin
            r_largest_log2 <= i_cfg_data;
        end
    end

    // Accept and classify each request transaction.
    pscm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_req        (s_axis_tdata[20:0]),
        .i_minc       (s_axis_tdata[36:21]),
        .i_largest    (r_largest_log2),
        .o_push       (front_push),
        .i_push_ready (queue_ready),
        .o_job        (front_job)
    );

    // Decouple the front from the walk.
    pscm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_push),
        .o_push_ready (queue_ready),
        .i_job        (front_job),
        .o_valid      (queue_valid),
        .i_pop        (queue_pop),
        .o_job        (queue_job)
    );

    // Walk the classes and hold each result until taken.
    pscm_back #(
        .MAX_PAGES_IN_RUN (MAX_PAGES_IN_RUN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .o_job_pop   (queue_pop),
        .i_job       (queue_job),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = {7'b0, result.total, result.cnt, result.idx};
    assign m_axis_tlast = result.last;
    assign m_axis_tuser = result.err;

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for page_size_class_mix: request stream in, class mix results out.
// Predicts every result from its own model of the class walk and checks it field by field.
// Depends on pscm_pkg and the page_size_class_mix RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_CAP          = pscm_pkg::MAX_PAGES_IN_RUN_DEF;
    localparam int PAGE_TOTAL_CAP   = int'(pscm_pkg::TOTAL_SAT);
    localparam int RESET_CYCLES     = 6;
    localparam int HOLD_CYCLES      = 300;   // long receiver hold-off for back pressure
    localparam int DRAIN_CYCLES     = 40;    // settle time before a register write
    localparam int END_CYCLES       = 100;   // settle time before the verdict
    localparam int WATCHDOG_LIMIT   = 3000;  // cycles with no transaction at all
    localparam int MAX_REPORTS      = 10;
    localparam int PHASE_ITEMS      = 41;

    typedef enum {TX_STEADY, TX_BURSTY} t_tx_mode;
    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} t_rx_mode;

    typedef struct {
        logic [20:0] pages;
        logic [15:0] min_class;
    } t_page_request;

    typedef struct {
        logic [3:0]  class_index;
        logic [15:0] class_count;
        logic [20:0] total_pages;
        logic        last;
        logic        error;
    } t_mix_result;

    // Clock and reset; every input starts at a known value.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // request_pages[20:0], min_class_pages[36:21]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // class_index[3:0], class_count[19:4], total_pages[40:20]
    logic        m_axis_tlast;
    logic        m_axis_tuser;         // error[0]

    always #2 i_clk = ~i_clk;

    page_size_class_mix #(
        .MAX_PAGES_IN_RUN(RUN_CAP)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Stimulus queues drained by the drivers, filled by the sequence; expected results from the monitor.
    t_page_request request_q[$];
    logic [3:0]    largest_q[$];
    t_mix_result   expected_mix_q[$];

    // Knobs set by the sequence at the falling edge, read by the drivers at the rising edge.
    t_tx_mode tx_mode = TX_BURSTY;
    t_rx_mode rx_mode = RX_ALWAYS;
    bit       pressure_arm = 1'b0;

    // Bookkeeping; each counter has one writer.
    int items_queued = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int cfg_accepted = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;
    logic [3:0] model_largest_log2 = pscm_pkg::LARGEST_RESET;

    // ------------------------------------------------------------------
    // Predictor: walk the size classes from the largest down and queue
    // every result the request should produce.
    // ------------------------------------------------------------------
    function automatic void predict_mix(input logic [20:0] pages, input logic [15:0] min_class,
                                        input logic [3:0] largest);
        int top, idx, needed, class_pages, max_runs, runs, total, n;
        bit smallest;
        t_mix_result r;
        top = (largest < pscm_pkg::LARGEST_FLOOR) ? int'(pscm_pkg::LARGEST_FLOOR)
                                                  : int'(largest);
        needed = int'(pages);
        total = 0;
        n = 0;
        idx = top;
        r = '{4'd0, 16'd0, 21'd0, 1'b1, 1'b1};
        // Minimum class above the largest class: one error result, nothing else.
        if (int'(min_class) > (1 << top)) begin
            expected_mix_q.insert(expected_mix_q.size(), r);
            return;
        end
        while (idx >= 0) begin
            class_pages = 1 << idx;
            // Smallest allowed: class 0, or the next smaller class is below the minimum.
            smallest = (idx == 0) || ((class_pages >> 1) < int'(min_class));
            max_runs = RUN_CAP / class_pages;
            if (longint'(class_pages) > longint'(needed) + longint'(needed / 8) && !smallest) begin
                idx--;
                continue;
            end
            if (max_runs == 0) begin
                // Class larger than one run: skip it, or fail when nothing smaller is allowed.
                if (smallest) begin
                    expected_mix_q.insert(expected_mix_q.size(), r);
                    return;
                end
                idx--;
                continue;
            end
            runs = 1;
            if (needed > 0 && needed / class_pages > 1)
                runs = needed / class_pages;
            if (runs > max_runs)
                runs = max_runs;
            needed -= runs * class_pages;
            // Round the remainder up on the smallest allowed class.
            if (smallest && needed > 0 && runs < max_runs) begin
                runs++;
                needed -= class_pages;
            end
            total += runs * class_pages;
            if (total > PAGE_TOTAL_CAP)
                total = PAGE_TOTAL_CAP + 1;
            r.class_index = idx[3:0];
            r.class_count = runs[15:0];
            r.total_pages = (total > PAGE_TOTAL_CAP) ? pscm_pkg::TOTAL_SAT : total[20:0];
            r.last = 1'b0;
            r.error = 1'b0;
            expected_mix_q.insert(expected_mix_q.size(), r);
            n++;
            if (needed <= 0 || n >= pscm_pkg::MAX_RESULTS)
                break;
            // A capped class is visited again.
            if (runs != max_runs)
                idx--;
        end
        if (n > 0)
            expected_mix_q[expected_mix_q.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: in bursty mode, bursts of random length with random gaps between them.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;
    t_page_request tx_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            burst_left = 0;
            gap_left = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (request_q.size() > 0) begin
                tx_item = request_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {3'b000, tx_item.min_class, tx_item.pages};
                if (tx_mode == TX_BURSTY) begin
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 16);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = $urandom_range(1, 7);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Register write driver: one transaction per queued value.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
            i_cfg_data <= '0;
        end else if (!i_cfg_valid || o_cfg_ready) begin
            if (largest_q.size() > 0) begin
                i_cfg_valid <= 1'b1;
                i_cfg_data <= largest_q.pop_front();
            end else begin
                i_cfg_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: stall on a rotating pattern, at random or not at all, and once
    // hold off for a long stretch so the block backs up into its input.
    // ------------------------------------------------------------------
    logic [7:0] stall_pattern = 8'b1101_0110;
    int  hold_left = 0;
    bit  pressure_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_pattern <= 8'b1101_0110;
        end else begin
            stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
            if (pressure_arm && !pressure_done) begin
                hold_left = HOLD_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: begin
                        m_axis_tready <= 1'b1;
                    end
                    RX_RANDOM: begin
                        m_axis_tready <= ($urandom_range(0, 9) < 7);
                    end
                    default: begin
                        m_axis_tready <= stall_pattern[0];
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check results first, then predict accepted requests and
    // track register writes, all in one process.
    // ------------------------------------------------------------------
    t_mix_result got, want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.class_index = m_axis_tdata[3:0];
                got.class_count = m_axis_tdata[19:4];
                got.total_pages = m_axis_tdata[40:20];
                got.last = m_axis_tlast;
                got.error = m_axis_tuser;
                if (expected_mix_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"[%0t] unexpected result: idx=%0d cnt=%0d total=%0d",
                                  " last=%0b err=%0b"},
                                 $realtime, got.class_index, got.class_count, got.total_pages,
                                 got.last, got.error);
                end else begin
                    want = expected_mix_q.pop_front();
                    if (got.class_index !== want.class_index
                        || got.class_count !== want.class_count
                        || got.total_pages !== want.total_pages || got.last !== want.last
                        || got.error !== want.error) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("[%0t] result %0d mismatch", $realtime, results_checked);
                            $display("    expected idx=%0d cnt=%0d total=%0d last=%0b err=%0b",
                                     want.class_index, want.class_count, want.total_pages,
                                     want.last, want.error);
                            $display("    actual   idx=%0d cnt=%0d total=%0d last=%0b err=%0b",
                                     got.class_index, got.class_count, got.total_pages,
                                     got.last, got.error);
                        end
                    end
                end
                results_checked++;
            end
            // A request taken with a register write uses the old setting.
            if (s_axis_tvalid && s_axis_tready) begin
                predict_mix(s_axis_tdata[20:0], s_axis_tdata[36:21], model_largest_log2);
                items_accepted++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                model_largest_log2 = i_cfg_data;
                cfg_accepted++;
            end
            if ((m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)
                || (s_axis_tvalid && s_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Watchdog: end the run when the block stops moving.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(negedge i_clk);
        $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("page_size_class_mix test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------
    task automatic queue_request(input logic [20:0] pages, input logic [15:0] min_class);
        t_page_request p;
        p.pages = pages;
        p.min_class = min_class;
        request_q.insert(request_q.size(), p);
        items_queued++;
    endtask

    // Wait until every request is in and every result is out, then settle.
    task automatic wait_drained();
        while (items_accepted != items_queued || expected_mix_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_largest(input logic [3:0] value);
        int target;
        target = cfg_accepted + 1;
        largest_q.insert(largest_q.size(), value);
        while (cfg_accepted < target)
            @(negedge i_clk);
    endtask

    // Mostly well-formed requests; a share of oversized minimums gives error results.
    function automatic t_page_request random_request(input int top);
        t_page_request p;
        int pick;
        bit [31:0] noise;
        noise = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            p.pages = 21'($urandom_range(0, 600));
        else if (pick < 65)
            p.pages = 21'($urandom_range(0, 70000));
        else if (pick < 85)
            p.pages = 21'($urandom_range(0, 1048576));
        else if (pick < 95)
            p.pages = noise[20:0];
        else
            case ($urandom_range(0, 3))
                0: p.pages = 21'd0;
                1: p.pages = 21'd1048576;
                2: p.pages = pscm_pkg::TOTAL_SAT;
                default: p.pages = 21'(RUN_CAP + 1);
            endcase
        noise = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            p.min_class = 16'(1 << $urandom_range(0, top));
        else if (pick < 72)
            p.min_class = 16'($urandom_range(1, 1 << top));
        else if (pick < 80)
            p.min_class = 16'd0;
        else if (pick < 88)
            p.min_class = 16'((1 << top) + $urandom_range(1, 3));
        else
            p.min_class = noise[15:0];
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    logic [3:0] phase_largest [10] = '{4'd15, 4'd0, 4'd12, 4'd8, 4'd9,
                                       4'd7, 4'd14, 4'd10, 4'd11, 4'd13};

    initial begin
        t_page_request p;
        int top;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset setting (largest class 2^8).
        rx_mode = RX_PATTERN;
        queue_request(21'd0, 16'd1);            // zero request
        queue_request(21'd0, 16'd256);          // zero request, smallest class is the largest
        queue_request(21'd1, 16'd1);
        queue_request(21'd7, 16'd1);            // class 8 too big even with the eighth
        queue_request(21'd9, 16'd8);            // class 8 is the smallest allowed, remainder rounded up
        queue_request(21'd1000, 16'd64);        // remainder rounded up on class 64
        queue_request(21'd65280, 16'd1);        // exactly one capped run of class 256
        queue_request(21'd65281, 16'd1);        // cap hit, same class visited again, then skipped
        queue_request(21'd1048576, 16'd1);
        queue_request(pscm_pkg::TOTAL_SAT, 16'd1);
        queue_request(pscm_pkg::TOTAL_SAT, 16'd256); // round up pushes the total past saturation
        queue_request(21'd300, 16'd256);
        queue_request(21'd300, 16'd257);        // minimum just above the largest class
        queue_request(21'd5, 16'd0);            // minimum of zero
        queue_request(pscm_pkg::TOTAL_SAT, 16'hFFFF); // all-ones minimum, error
        queue_request(21'd12345, 16'h8000);
        wait_drained();

        // Largest class 2^15: the result count limit and the widest minimum.
        write_largest(4'd15);
        rx_mode = RX_RANDOM;
        queue_request(pscm_pkg::TOTAL_SAT, 16'd1);     // stops after the last allowed result
        queue_request(pscm_pkg::TOTAL_SAT, 16'd32768);
        queue_request(21'd100, 16'd32769);      // just above 2^15, error
        queue_request(21'd0, 16'd32768);
        wait_drained();

        // A register value below the floor acts as the floor.
        write_largest(4'd0);
        rx_mode = RX_ALWAYS;
        queue_request(21'd500, 16'd256);
        queue_request(21'd500, 16'd257);
        queue_request(21'd65535, 16'd3);
        wait_drained();

        // Random phases over several settings, with varied pacing on both sides.
        for (int ph = 0; ph < 10; ph++) begin
            write_largest(phase_largest[ph]);
            top = (phase_largest[ph] < pscm_pkg::LARGEST_FLOOR)
                ? int'(pscm_pkg::LARGEST_FLOOR) : int'(phase_largest[ph]);
            tx_mode = (ph % 3 == 2) ? TX_STEADY : TX_BURSTY;
            case (ph % 3)
                0: rx_mode = RX_RANDOM;
                1: rx_mode = RX_PATTERN;
                default: rx_mode = RX_ALWAYS;
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                p = random_request(top);
                queue_request(p.pages, p.min_class);
            end
            // Hold off the receiver once while the sender keeps offering.
            if (ph == 2)
                pressure_arm = 1'b1;
            wait_drained();
        end

        repeat (END_CYCLES) @(negedge i_clk);
        $display("Run covered %0d requests and %0d checked results over %0d register writes,",
                 items_accepted, results_checked, cfg_accepted);
        $display("with bursty and steady senders, three receiver stall styles, one long hold-off.");
        if (mismatch_count == 0 && expected_mix_q.size() == 0) begin
            $display("page_size_class_mix test passed");
        end else begin
            $display("%0d mismatches, %0d results still expected", mismatch_count,
                     expected_mix_q.size());
            $display("page_size_class_mix test failed");
        end
        $finish;
    end

endmodule
